// ===== rtl/sds_pkg.sv =====
// sds_pkg: shared types, constants and microcode for the scale degree stepper.
// Used by sds_seq, sds_dp and the top level; no dependencies.
package sds_pkg;

  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned PC_W    = 4;
  localparam int unsigned MASK_W  = 12;
  localparam int unsigned UPC_W   = 3;

  localparam logic [NOTE_W-1:0] MAX_NOTE    = 7'd60;
  localparam logic [MASK_W-1:0] MASK_RESET  = 12'hFFF;
  localparam logic [PC_W-1:0]   PC_LAST     = 4'd11;
  localparam logic [STEP_W-1:0] STEP_MOST_NEG = 8'h80;
  localparam logic [CNT_W-1:0]  CNT_SAT     = 7'd127;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_BEGIN,   // cursor <= note
    OP_STEP,    // cursor moves one semitone
    OP_COMMIT,  // note <= cursor, count--
    OP_EMIT     // result into output register
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_BEAT,
    COND_DONE,
    COND_BLOCKED,
    COND_MISS,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic in_fire;
    logic done;
    logic blocked;
    logic miss;
    logic out_busy;
  } flags_t;

  localparam logic [UPC_W-1:0] UA_WAIT   = 3'd0;
  localparam logic [UPC_W-1:0] UA_CHECK  = 3'd1;
  localparam logic [UPC_W-1:0] UA_BEGIN  = 3'd2;
  localparam logic [UPC_W-1:0] UA_WALK   = 3'd3;
  localparam logic [UPC_W-1:0] UA_TEST   = 3'd4;
  localparam logic [UPC_W-1:0] UA_COMMIT = 3'd5;
  localparam logic [UPC_W-1:0] UA_SPARE  = 3'd6;
  localparam logic [UPC_W-1:0] UA_EMIT   = 3'd7;

  // Control store. Fall-through is upc+1; EMIT wraps to WAIT.
  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: UA_WAIT};
    case (addr)
      UA_WAIT:   w = '{op: OP_NOP,    cond: COND_NO_BEAT,  target: UA_WAIT};
      UA_CHECK:  w = '{op: OP_NOP,    cond: COND_DONE,     target: UA_EMIT};
      UA_BEGIN:  w = '{op: OP_BEGIN,  cond: COND_NEVER,    target: UA_WAIT};
      UA_WALK:   w = '{op: OP_STEP,   cond: COND_BLOCKED,  target: UA_EMIT};
      UA_TEST:   w = '{op: OP_NOP,    cond: COND_MISS,     target: UA_WALK};
      UA_COMMIT: w = '{op: OP_COMMIT, cond: COND_ALWAYS,   target: UA_CHECK};
      UA_SPARE:  w = '{op: OP_NOP,    cond: COND_ALWAYS,   target: UA_WAIT};
      UA_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_BUSY, target: UA_EMIT};
      default:   w = '{op: OP_NOP,    cond: COND_ALWAYS,   target: UA_WAIT};
    endcase
    return w;
  endfunction

  // n mod 12 for a 7-bit note: quotient by reciprocal 43/512, exact below 128
  function automatic logic [PC_W-1:0] mod12(input logic [NOTE_W-1:0] n);
    logic [12:0] prod;
    logic [3:0]  q;
    logic [6:0]  q12;
    logic [6:0]  r;
    prod = 13'(n) * 13'd43;
    q    = prod[12:9];
    q12  = 7'({q, 3'b000}) + 7'({q, 2'b00});
    r    = n - q12;
    return r[PC_W-1:0];
  endfunction

endpackage

// ===== rtl/scale_degree_stepper.sv =====
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tdata[6:0] start_note, [14:7] step_count
// m_axis    out  tvalid/tready          tdata[6:0] result_note
// cfg       in   cfg_wr_en              cfg_wr_data[11:0] scale_mask
//
// One beat in, one beat out. Each degree runs the microcode walk loop of a WALK
// and a TEST step per semitone walked, then a COMMIT; a degree blocked at a
// boundary ends the walk early. At most 127 degrees are walked per beat.
// rst is synchronous; it sets the mask to all pitch classes and empties the output.
// s_axis_tready is high only while the sequencer waits; a stalled output
// beat holds the sequencer at its emit step after the next beat is taken.
//
// Top level: instantiates sds_seq and sds_dp; depends on sds_pkg.
module scale_degree_stepper (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [6:0] start_note, [14:7] step_count, [15] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] result_note, [7] zero
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data     // scale_mask
);

  sds_pkg::op_t                op;
  sds_pkg::flags_t             flags;
  logic                        idle;
  logic                        in_fire;
  logic [sds_pkg::NOTE_W-1:0]  result_note;

  assign s_axis_tready = idle;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {1'b0, result_note};

  sds_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .op    (op),
    .idle  (idle)
  );

  sds_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .in_fire     (in_fire),
    .start_note  (s_axis_tdata[6:0]),
    .step_count  (s_axis_tdata[14:7]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .result_note (result_note),
    .flags       (flags)
  );

endmodule

// ===== rtl/sds_seq.sv =====
// sds_seq: microcode sequencer, step counter plus conditional jump.
// Depends on sds_pkg (control store, op and condition codes).
module sds_seq (
  input  logic              clk,
  input  logic              rst,
  input  sds_pkg::flags_t   flags,
  output sds_pkg::op_t      op,
  output logic              idle
);

  logic [sds_pkg::UPC_W-1:0] upc;
  logic [sds_pkg::UPC_W-1:0] upc_next;
  sds_pkg::uword_t           uw;
  logic                      take;

  assign uw   = sds_pkg::ucode(upc);
  assign op   = uw.op;
  assign idle = (upc == sds_pkg::UA_WAIT);

  always_comb begin
    unique case (uw.cond)
      sds_pkg::COND_NEVER:    take = 1'b0;
      sds_pkg::COND_ALWAYS:   take = 1'b1;
      sds_pkg::COND_NO_BEAT:  take = !flags.in_fire;
      sds_pkg::COND_DONE:     take = flags.done;
      sds_pkg::COND_BLOCKED:  take = flags.blocked;
      sds_pkg::COND_MISS:     take = flags.miss;
      sds_pkg::COND_OUT_BUSY: take = flags.out_busy;
      default:                take = 1'b1;
    endcase
    upc_next = take ? uw.target : upc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= sds_pkg::UA_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== rtl/sds_dp.sv =====
// sds_dp: note, cursor, degree count, scale mask and output register.
// Depends on sds_pkg; driven by op codes from sds_seq.
module sds_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  sds_pkg::op_t                op,
  input  logic                        in_fire,
  input  logic [sds_pkg::NOTE_W-1:0]  start_note,
  input  logic [sds_pkg::STEP_W-1:0]  step_count,
  input  logic                        cfg_wr_en,
  input  logic [sds_pkg::MASK_W-1:0]  cfg_wr_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [sds_pkg::NOTE_W-1:0]  result_note,
  output sds_pkg::flags_t             flags
);

  logic [sds_pkg::MASK_W-1:0] scale_mask;
  logic [sds_pkg::NOTE_W-1:0] note;
  logic [sds_pkg::PC_W-1:0]   note_pc;
  logic [sds_pkg::NOTE_W-1:0] cur;
  logic [sds_pkg::PC_W-1:0]   cur_pc;
  logic [sds_pkg::CNT_W-1:0]  count;
  logic                       up;
  logic [sds_pkg::CNT_W-1:0]  count_in;
  logic [sds_pkg::STEP_W-1:0] step_neg;
  logic                       out_busy;

  // magnitude of the step count; the most negative code saturates
  always_comb begin
    step_neg = -step_count;
    if (!step_count[sds_pkg::STEP_W-1]) begin
      count_in = step_count[sds_pkg::CNT_W-1:0];
    end else if (step_count == sds_pkg::STEP_MOST_NEG) begin
      count_in = sds_pkg::CNT_SAT;
    end else begin
      count_in = step_neg[sds_pkg::CNT_W-1:0];
    end
  end

  assign out_busy = out_valid && !out_ready;

  assign flags.in_fire  = in_fire;
  assign flags.done     = (count == '0) || (scale_mask == '0);
  assign flags.blocked  = up ? (cur >= sds_pkg::MAX_NOTE) : (cur == '0);
  assign flags.miss     = !scale_mask[cur_pc];
  assign flags.out_busy = out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mask <= sds_pkg::MASK_RESET;
    end else if (cfg_wr_en) begin
      scale_mask <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      note    <= start_note;
      note_pc <= sds_pkg::mod12(start_note);
      count   <= count_in;
      up      <= !step_count[sds_pkg::STEP_W-1];
    end else begin
      case (op)
        sds_pkg::OP_BEGIN: begin
          cur    <= note;
          cur_pc <= note_pc;
        end
        sds_pkg::OP_STEP: begin
          if (up) begin
            cur    <= cur + 1'b1;
            cur_pc <= (cur_pc == sds_pkg::PC_LAST) ? '0 : cur_pc + 1'b1;
          end else begin
            cur    <= cur - 1'b1;
            cur_pc <= (cur_pc == '0) ? sds_pkg::PC_LAST : cur_pc - 1'b1;
          end
        end
        sds_pkg::OP_COMMIT: begin
          note    <= cur;
          note_pc <= cur_pc;
          count   <= count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output register; a waiting result does not block the next input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == sds_pkg::OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == sds_pkg::OP_EMIT && !out_busy) begin
      result_note <= note;
    end
  end

endmodule

// ===== rtl/sds_chk.sv =====
// sds_chk: port-level checks for scale_degree_stepper, bound to the top level.
// No package dependency; sees the top level's ports only.
module sds_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        cfg_wr_en,
  input logic [11:0] cfg_wr_data
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // one beat in flight: no back-to-back input beats
  a_in_gap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken in consecutive cycles");

  // a new result only appears once the sequencer has left its wait step
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without work in progress");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind scale_degree_stepper sds_chk u_chk (.*);
